>>> rtl/gbl_pkg.sv
package gbl_pkg;

    localparam int LIMIT_W     = 32;
    localparam int ALPHA_W     = 16;
    localparam int COUNT_W     = 13;
    localparam int BIAS_W      = 32;
    localparam int ALPHA_SHIFT = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 2'd3;

    localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST = 32'd41943;
    localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST  = 32'd141250;
    localparam logic [ALPHA_W-1:0] ALPHA_RST       = 16'd3277;
    localparam logic [COUNT_W-1:0] SETTLE_RST      = 13'd200;

    typedef struct packed {
        logic [LIMIT_W-1:0] accel_limit;
        logic [LIMIT_W-1:0] gyro_limit;
        logic [ALPHA_W-1:0] alpha;
        logic [COUNT_W-1:0] settle;
    } cfg_t;

    typedef struct packed {
        logic still_seen;
        logic bias_valid;
    } flags_t;

endpackage

>>> rtl/gyro_bias_learner.sv
// channel  | ports                  | beat contents (lowest bits first)
// s_ (in)  | s_tvalid/tready/tdata  | accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
// m_ (out) | m_tvalid/tready/tdata  | rate_x, rate_y, rate_z; tuser: bias_valid, still_seen
// cfg      | cfg_valid/ready/index  | cfg_data to register cfg_index, always ready
//
// One beat per cycle while m_tready is high; each beat passes input, then result register.
// The whole bias update and correction run in the cycle a beat moves to the result register.
// Synchronous active-low reset clears last accel, biases, settle counter and bias_valid.
// A stalled result register holds; the input register still takes one beat behind it.
module gyro_bias_learner #(
    parameter int SAMPLE_BITS        = 16,
    parameter int BIAS_FRACTION_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, zero padding
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // rate_x, rate_y, rate_z, zero padding
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
    // bias_valid, still_seen
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gbl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gbl_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int S     = SAMPLE_BITS;
    localparam int OUT_W = ((3 * S + 7) / 8) * 8;

    gbl_pkg::cfg_t     cfg;
    gbl_pkg::flags_t   flags;
    gbl_pkg::flags_t   flags_reg;

    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0][S-1:0] accel_reg;
    logic [2:0][S-1:0] gyro_reg;
    logic [2:0][S-1:0] rate;
    logic [2:0][S-1:0] rate_reg;
    logic              advance;
    logic              still;
    logic              bias_valid;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        flags.still_seen = still;
        flags.bias_valid = bias_valid;
    end

    gbl_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    gbl_still_detect #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_still (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .accel       (accel_reg),
        .gyro        (gyro_reg),
        .accel_limit (cfg.accel_limit),
        .gyro_limit  (cfg.gyro_limit),
        .still       (still)
    );

    gbl_bias_track #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .BIAS_FRACTION_BITS (BIAS_FRACTION_BITS)
    ) u_bias (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .still      (still),
        .gyro       (gyro_reg),
        .alpha      (cfg.alpha),
        .settle     (cfg.settle),
        .rate       (rate),
        .bias_valid (bias_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
                accel_reg[i] <= s_tdata[i*S +: S];
                gyro_reg[i]  <= s_tdata[(i+3)*S +: S];
            end
        end
        if (advance) begin
            rate_reg  <= rate;
            flags_reg <= flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(rate_reg);
    assign m_tuser  = {flags_reg.still_seen, flags_reg.bias_valid};

endmodule

>>> rtl/gbl_cfg_regs.sv
module gbl_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [gbl_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [gbl_pkg::CFG_DATA_W-1:0]     wr_data,
    output gbl_pkg::cfg_t                      cfg
);

    gbl_pkg::cfg_t cfg_reg;
    gbl_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                gbl_pkg::REG_ACCEL_LIMIT: cfg_next.accel_limit = wr_data;
                gbl_pkg::REG_GYRO_LIMIT:  cfg_next.gyro_limit  = wr_data;
                gbl_pkg::REG_ALPHA:       cfg_next.alpha  = wr_data[gbl_pkg::ALPHA_W-1:0];
                gbl_pkg::REG_SETTLE:      cfg_next.settle = wr_data[gbl_pkg::COUNT_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_limit <= gbl_pkg::ACCEL_LIMIT_RST;
            cfg_reg.gyro_limit  <= gbl_pkg::GYRO_LIMIT_RST;
            cfg_reg.alpha       <= gbl_pkg::ALPHA_RST;
            cfg_reg.settle      <= gbl_pkg::SETTLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/gbl_still_detect.sv
module gbl_still_detect #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [2:0][SAMPLE_BITS-1:0]   accel,
    input  logic [2:0][SAMPLE_BITS-1:0]   gyro,
    input  logic [gbl_pkg::LIMIT_W-1:0]   accel_limit,
    input  logic [gbl_pkg::LIMIT_W-1:0]   gyro_limit,
    output logic                          still
);

    localparam int S    = SAMPLE_BITS;
    localparam int SQ_W = (2 * S + 2 > gbl_pkg::LIMIT_W) ? 2 * S + 2 : gbl_pkg::LIMIT_W;

    logic [2:0][S-1:0]    last_accel_reg;
    logic signed [S-1:0]  acc_s  [3];
    logic signed [S-1:0]  last_s [3];
    logic signed [S-1:0]  gyr_s  [3];
    logic signed [S:0]    diff   [3];
    logic signed [2*S+1:0] diff_sq [3];
    logic signed [2*S-1:0] gyro_sq [3];
    logic [SQ_W-1:0]      dsq_sum;
    logic [SQ_W-1:0]      gsq_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_s[i]   = accel[i];
            last_s[i]  = last_accel_reg[i];
            gyr_s[i]   = gyro[i];
            diff[i]    = (S+1)'(last_s[i]) - (S+1)'(acc_s[i]);
            diff_sq[i] = diff[i] * diff[i];
            gyro_sq[i] = gyr_s[i] * gyr_s[i];
        end
        dsq_sum = SQ_W'($unsigned(diff_sq[0])) + SQ_W'($unsigned(diff_sq[1]))
                + SQ_W'($unsigned(diff_sq[2]));
        gsq_sum = SQ_W'($unsigned(gyro_sq[0])) + SQ_W'($unsigned(gyro_sq[1]))
                + SQ_W'($unsigned(gyro_sq[2]));
        still   = (dsq_sum < SQ_W'(accel_limit)) && (gsq_sum < SQ_W'(gyro_limit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_accel_reg <= '0;
        end else if (advance) begin
            last_accel_reg <= accel;
        end
    end

endmodule

>>> rtl/gbl_bias_track.sv
module gbl_bias_track #(
    parameter int SAMPLE_BITS        = 16,
    parameter int BIAS_FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          still,
    input  logic [2:0][SAMPLE_BITS-1:0]   gyro,
    input  logic [gbl_pkg::ALPHA_W-1:0]   alpha,
    input  logic [gbl_pkg::COUNT_W-1:0]   settle,
    output logic [2:0][SAMPLE_BITS-1:0]   rate,
    output logic                          bias_valid
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = BIAS_FRACTION_BITS;
    localparam int BW  = gbl_pkg::BIAS_W;
    localparam int AW  = gbl_pkg::ALPHA_W;
    localparam int SH  = gbl_pkg::ALPHA_SHIFT;
    localparam int TA  = BW + AW + 2;
    localparam int TB  = AW + S + 1 + F;
    localparam int T_W = ((TA > TB) ? TA : TB) + 2;
    localparam int C_W = ((S + F > BW) ? S + F : BW) + 2;

    logic signed [BW-1:0]  bias_reg  [3];
    logic signed [BW-1:0]  bias_next [3];
    logic [gbl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                  valid_reg, valid_next;

    logic [AW:0]           keep;
    logic signed [AW+1:0]  keep_s;
    logic signed [AW:0]    alpha_s;
    logic signed [S-1:0]   g      [3];
    logic signed [T_W-1:0] p_keep [3];
    logic signed [AW+S:0]  p_learn [3];
    logic signed [T_W-1:0] t_sum  [3];
    logic signed [T_W-1:0] t_shr  [3];
    logic signed [BW-1:0]  t_sat  [3];
    logic signed [C_W-1:0] c_sum  [3];
    logic signed [C_W-1:0] c_shr  [3];

    always_comb begin
        keep    = {1'b1, {AW{1'b0}}} - {1'b0, alpha};
        keep_s  = {1'b0, keep};
        alpha_s = {1'b0, alpha};
        for (int i = 0; i < 3; i++) begin
            g[i]       = gyro[i];
            p_keep[i]  = keep_s * bias_reg[i];
            p_learn[i] = alpha_s * g[i];
            t_sum[i]   = p_keep[i] + (T_W'(p_learn[i]) <<< F) + (T_W'(1) <<< (SH - 1));
            t_shr[i]   = t_sum[i] >>> SH;
            if (&t_shr[i][T_W-1:BW-1] || ~|t_shr[i][T_W-1:BW-1]) begin
                t_sat[i] = t_shr[i][BW-1:0];
            end else begin
                t_sat[i] = {t_shr[i][T_W-1], {(BW-1){~t_shr[i][T_W-1]}}};
            end
            bias_next[i] = still ? t_sat[i] : bias_reg[i];

            c_sum[i] = (C_W'(g[i]) <<< F) - C_W'(bias_next[i]) + (C_W'(1) <<< (F - 1));
            c_shr[i] = c_sum[i] >>> F;
            if (&c_shr[i][C_W-1:S-1] || ~|c_shr[i][C_W-1:S-1]) begin
                rate[i] = c_shr[i][S-1:0];
            end else begin
                rate[i] = {c_shr[i][C_W-1], {(S-1){~c_shr[i][C_W-1]}}};
            end
        end

        count_next = count_reg;
        valid_next = valid_reg;
        if (still && (count_reg < settle)) begin
            count_next = count_reg + 1'b1;
            if (count_next == settle) begin
                valid_next = 1'b1;
            end
        end
        bias_valid = valid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                bias_reg[i] <= '0;
            end
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < 3; i++) begin
                bias_reg[i] <= bias_next[i];
            end
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> dv/tb_gyro_bias_learner.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [2:0][15:0] gyro;
    logic [2:0][15:0] accel;
} imu_sample_t;

typedef struct {
    logic [15:0] rate[3];
    logic        bias_valid;
    logic        still_seen;
} rate_result_t;

class rate_scoreboard;
    longint       accel_limit;
    longint       gyro_limit;
    longint       alpha;
    longint       settle;
    longint       prev_accel[3];
    longint       bias_q16[3];
    longint       still_count;
    bit           bias_learned;
    rate_result_t expected_rates[$];
    int           errors;

    function new();
        accel_limit  = gbl_pkg::ACCEL_LIMIT_RST;
        gyro_limit   = gbl_pkg::GYRO_LIMIT_RST;
        alpha        = gbl_pkg::ALPHA_RST;
        settle       = gbl_pkg::SETTLE_RST;
        for (int i = 0; i < 3; i++) begin
            prev_accel[i] = 0;
            bias_q16[i]   = 0;
        end
        still_count  = 0;
        bias_learned = 0;
        errors       = 0;
    endfunction

    static function longint limit_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int pending();
        return expected_rates.size();
    endfunction

    task flag_mismatch(string msg);
        if (errors < 100)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function void write_reg(logic [gbl_pkg::CFG_IDX_W-1:0] idx,
                            logic [gbl_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            gbl_pkg::REG_ACCEL_LIMIT: accel_limit = data;
            gbl_pkg::REG_GYRO_LIMIT:  gyro_limit  = data;
            gbl_pkg::REG_ALPHA:       alpha       = data[15:0];
            gbl_pkg::REG_SETTLE:      settle      = data[12:0];
            default: ;
        endcase
    endfunction

    function void take_sample(imu_sample_t smp);
        longint       acc;
        longint       gyr[3];
        longint       d;
        longint       dsq;
        longint       gsq;
        longint       t;
        longint       v;
        bit           still;
        rate_result_t want;
        dsq = 0;
        gsq = 0;
        for (int i = 0; i < 3; i++) begin
            acc    = $signed(smp.accel[i]);
            gyr[i] = $signed(smp.gyro[i]);
            d      = prev_accel[i] - acc;
            dsq   += d * d;
            gsq   += gyr[i] * gyr[i];
            prev_accel[i] = acc;
        end
        still = (dsq < accel_limit) && (gsq < gyro_limit);
        if (still) begin
            for (int i = 0; i < 3; i++) begin
                t = (65536 - alpha) * bias_q16[i] + alpha * (gyr[i] <<< 16);
                bias_q16[i] = limit_to((t + 32768) >>> 16, -64'sd2147483648, 64'sd2147483647);
            end
            if (still_count < settle) begin
                still_count++;
                if (still_count == settle)
                    bias_learned = 1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            v = ((gyr[i] <<< 16) - bias_q16[i] + 32768) >>> 16;
            v = limit_to(v, -32768, 32767);
            want.rate[i] = v[15:0];
        end
        want.bias_valid = bias_learned;
        want.still_seen = still;
        expected_rates.push_back(want);
    endfunction

    task check_rate(rate_result_t got);
        rate_result_t want;
        if (expected_rates.size() == 0) begin
            flag_mismatch("result beat with no sample waiting");
            return;
        end
        want = expected_rates.pop_front();
        for (int i = 0; i < 3; i++)
            if (got.rate[i] !== want.rate[i])
                flag_mismatch($sformatf("rate[%0d] got %0d expected %0d", i,
                                        $signed(got.rate[i]), $signed(want.rate[i])));
        if (got.bias_valid !== want.bias_valid)
            flag_mismatch($sformatf("bias_valid got %b expected %b",
                                    got.bias_valid, want.bias_valid));
        if (got.still_seen !== want.still_seen)
            flag_mismatch($sformatf("still_seen got %b expected %b",
                                    got.still_seen, want.still_seen));
    endtask
endclass

module tb_gyro_bias_learner;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     HOLD_CYCLES = 300;
    localparam logic [31:0] LIMIT_MAX = 32'hFFFF_FFFF;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [95:0]                     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [47:0]                     m_tdata;
    logic [1:0]                      m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gbl_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [gbl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    rate_scoreboard rates = new();
    rate_result_t   seen_rate;
    bit             gaps_on    = 1'b1;
    bit             hold_req   = 1'b0;
    int             hold_left  = 0;
    int             stall_left = 0;
    longint         cycles     = 0;
    int             pose[3];
    int             drift[3];
    int             phase;
    logic [12:0]    settle_pick;

    always #5 aclk = ~aclk;

    gyro_bias_learner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] sat16(int v);
        return (v > 32767) ? 16'h7FFF : ((v < -32768) ? 16'h8000 : v[15:0]);
    endfunction

    function automatic imu_sample_t pack_imu(int ax, int ay, int az, int gx, int gy, int gz);
        imu_sample_t smp;
        smp.accel[0] = ax[15:0];
        smp.accel[1] = ay[15:0];
        smp.accel[2] = az[15:0];
        smp.gyro[0]  = gx[15:0];
        smp.gyro[1]  = gy[15:0];
        smp.gyro[2]  = gz[15:0];
        return smp;
    endfunction

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_rate.rate[0]    = m_tdata[15:0];
            seen_rate.rate[1]    = m_tdata[31:16];
            seen_rate.rate[2]    = m_tdata[47:32];
            seen_rate.bias_valid = m_tuser[0];
            seen_rate.still_seen = m_tuser[1];
            rates.check_rate(seen_rate);
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (gaps_on)
                stall_left = pick_gap();
        end
    end

    task automatic send_sample(imu_sample_t smp);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = smp;
        do @(posedge aclk); while (!s_tready);
        rates.take_sample(smp);
        if (gaps_on) begin
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic write_reg(logic [gbl_pkg::CFG_IDX_W-1:0] idx,
                             logic [gbl_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        rates.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (rates.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic retune(logic [31:0] accel_lim, logic [31:0] gyro_lim,
                          logic [15:0] alpha_w, logic [12:0] settle_w);
        drain();
        write_reg(gbl_pkg::REG_ACCEL_LIMIT, accel_lim);
        write_reg(gbl_pkg::REG_GYRO_LIMIT, gyro_lim);
        write_reg(gbl_pkg::REG_ALPHA, {16'b0, alpha_w});
        write_reg(gbl_pkg::REG_SETTLE, {19'b0, settle_w});
    endtask

    task automatic run_phase(int count);
        int          r;
        int          k;
        imu_sample_t smp;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                for (k = 0; k < 3; k++)
                    pose[k] = int'($urandom_range(0, 40000)) - 20000;
            if (r < 85) begin
                for (k = 0; k < 3; k++) begin
                    pose[k]      = $signed(sat16(pose[k] + jitter(40)));
                    smp.accel[k] = pose[k][15:0];
                    smp.gyro[k]  = sat16(drift[k] + jitter(40));
                end
                if (r >= 78)
                    smp.gyro[2'($urandom_range(0, 2))] = 16'($urandom);
            end else begin
                smp = {$urandom, $urandom, $urandom};
            end
            send_sample(smp);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults; first sample is measured against zero accel
        send_sample(pack_imu(100, -50, 30, 10, -20, 5));
        send_sample(pack_imu(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(pack_imu(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(pack_imu(-32768, -32768, -32768, 0, 0, 0));
        send_sample(pack_imu(0, 0, 0, 0, 0, 0));

        retune(LIMIT_MAX, LIMIT_MAX, 16'hFFFF, 13'h1FFF);
        repeat (3) send_sample(pack_imu(0, 0, 0, 32767, 32767, 32767));
        send_sample(pack_imu(-32768, -32768, -32768, 32767, 32767, 32767));
        send_sample(pack_imu(32767, 32767, 32767, -32768, -32768, -32768));

        // zero limits: nothing is still
        retune('0, '0, '0, '0);
        send_sample(pack_imu(-1, -1, -1, 0, 0, 0));
        send_sample(pack_imu(-1, -1, -1, 1, 1, 1));

        // zero alpha and zero settle count: bias and counter hold
        retune(LIMIT_MAX, LIMIT_MAX, '0, '0);
        send_sample(pack_imu(-1, -1, -1, 0, 0, 0));
        send_sample(pack_imu(-1, -1, -1, -300, 200, 7));

        retune(LIMIT_MAX, LIMIT_MAX, 16'hFFFF, 13'h1FFF);
        repeat (3) send_sample(pack_imu(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(pack_imu(32767, 32767, 32767, 32767, 32767, 32767));

        // settle count lowered below the counter
        drain();
        write_reg(gbl_pkg::REG_SETTLE, 32'd3);
        send_sample(pack_imu(32767, 32767, 32767, 5, 5, 5));
        send_sample(pack_imu(32767, 32767, 32767, -5, 3, 0));

        for (phase = 0; phase < 8; phase++) begin
            settle_pick = (phase == 0) ? 13'(rates.still_count + $urandom_range(20, 80))
                                       : 13'($urandom_range(1, 40));
            case (phase % 4)
                0: retune(gbl_pkg::ACCEL_LIMIT_RST, gbl_pkg::GYRO_LIMIT_RST,
                          gbl_pkg::ALPHA_RST, settle_pick);
                1: retune($urandom_range(1000, 200000), $urandom_range(1000, 300000),
                          16'($urandom), 13'($urandom_range(1, 60)));
                2: retune(LIMIT_MAX, LIMIT_MAX, 16'($urandom), 13'h1FFF);
                default: retune($urandom, $urandom, 16'($urandom), 13'd1);
            endcase
            for (int k = 0; k < 3; k++) begin
                drift[k] = jitter(150);
                pose[k]  = int'($urandom_range(0, 40000)) - 20000;
            end
            gaps_on = (phase != 5);
            if (phase == 2) begin
                @(posedge aclk);
                hold_req = 1'b1;
            end
            run_phase(200);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (rates.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> gyro_bias_learner.f
rtl/gbl_pkg.sv
rtl/gbl_cfg_regs.sv
rtl/gbl_still_detect.sv
rtl/gbl_bias_track.sv
rtl/gyro_bias_learner.sv
dv/tb_gyro_bias_learner.sv
